/* sv/wbps_pkg.sv */
// Shared types and constants of the wildcard byte pattern scanner.
`default_nettype none
package wbps_pkg;

   localparam int MAX_PATTERN = 64;
   localparam int SEL_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   localparam int LEN_W    = 7;
   localparam int ENTRY_W  = 6;
   localparam int ADDR_W   = 48;
   localparam int OFFSET_W = 32;
   localparam int POS_W    = 32;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [1:0] {
      REG_PATTERN_LENGTH = 2'd0,
      REG_BASE_ADDRESS   = 2'd1,
      REG_MATCH_OFFSET   = 2'd2
   } reg_index_type;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_SCAN = 1'b1
   } cmd_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic       scan_en;
      logic       clear;
      logic [7:0] scan_byte;
      logic [7:0] load_byte;
      logic       load_wild;
   } cell_ctl_type;

   // one result headed for the output stages
   typedef struct packed {
      logic              found;
      logic [POS_W-1:0]  start;
      logic [ADDR_W-1:0] base;
      logic [OFFSET_W-1:0] offset;
   } hit_type;

endpackage
`default_nettype wire

/* sv/wildcard_byte_pattern_scanner_unit.sv */
// Top level of the wildcard byte pattern scanner: registers, cell row, control.
`default_nettype none
// Takes one beat per clock, pattern loads and image bytes alike. Each of the
// 64 cells compares the incoming byte with its pattern entry and passes its
// partial match bit to the next cell, so all start positions are tracked in
// parallel. The found / not-found result of the matching or final byte goes
// through the address-sum stage and the output register to the rsp_ channel;
// req_stall rises only when both result stages hold a beat and rsp_stall is
// high. Registers sit at byte addresses 0 (pattern_length), 8 (base_address)
// and 16 (match_offset), 64 bits wide; write them only while the block is idle.
// Unloaded pattern entries used by a scan give undefined results.
module wildcard_byte_pattern_scanner_unit
   import wbps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_cmd,
   input  wire logic [ENTRY_W-1:0]    req_entry_index,
   input  wire logic [7:0]            req_byte_value,
   input  wire logic                  req_is_wildcard,
   input  wire logic                  req_is_last,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_found,
   output logic [ADDR_W-1:0]          rsp_match_address,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   logic [LEN_W-1:0]    pattern_length_ff;
   logic [ADDR_W-1:0]   base_address_ff;
   logic [OFFSET_W-1:0] match_offset_ff;
   logic [POS_W-1:0]    byte_position_ff, byte_position_in;
   logic                search_done_ff, search_done_in;

   reg_index_type       reg_sel;
   logic                csr_write;
   logic                accept, scan_acc, load_acc, shift;
   logic [SEL_W-1:0]    len_sel;
   logic                tap;
   logic                busy;
   logic                hit_valid;
   hit_type             hit;
   cell_ctl_type        ctl;
   logic [MAX_PATTERN-1:0] match_vec;
   logic [MAX_PATTERN-1:0] next_vec;
   logic [MAX_PATTERN-1:0] load_sel;

   // configuration port
   assign pready    = 1'b1;
   assign reg_sel   = reg_index_type'(paddr[4:3]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= LEN_W'(1);
         base_address_ff   <= '0;
         match_offset_ff   <= '0;
      end else if (csr_write) begin
         unique case (reg_sel)
            REG_PATTERN_LENGTH: pattern_length_ff <= pwdata[LEN_W-1:0];
            REG_BASE_ADDRESS:   base_address_ff   <= pwdata[ADDR_W-1:0];
            REG_MATCH_OFFSET:   match_offset_ff   <= pwdata[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_PATTERN_LENGTH: prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, pattern_length_ff};
         REG_BASE_ADDRESS:   prdata = {{(CSR_DATA_W-ADDR_W){1'b0}}, base_address_ff};
         REG_MATCH_OFFSET:   prdata = {{(CSR_DATA_W-OFFSET_W){1'b0}}, match_offset_ff};
         default:            prdata = '0;
      endcase
   end

   // beat decode
   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;
   assign scan_acc  = accept && (cmd_type'(req_cmd) == CMD_SCAN);
   assign load_acc  = accept && (cmd_type'(req_cmd) == CMD_LOAD);
   assign shift     = scan_acc && !search_done_ff;

   assign ctl.scan_en   = shift;
   assign ctl.clear     = scan_acc && req_is_last;
   assign ctl.scan_byte = req_byte_value;
   assign ctl.load_byte = req_byte_value;
   assign ctl.load_wild = req_is_wildcard;

   // length 0 acts as 1, lengths past the row act as the full row
   always_comb begin
      if (pattern_length_ff == '0) begin
         len_sel = '0;
      end else if (int'(pattern_length_ff) > MAX_PATTERN) begin
         len_sel = SEL_W'(MAX_PATTERN - 1);
      end else begin
         len_sel = SEL_W'(pattern_length_ff - LEN_W'(1));
      end
   end

   genvar j;
   generate
      for (j = 0; j < MAX_PATTERN; j++) begin : g_cell
         logic prev;
         if (j == 0) begin : g_head
            assign prev = 1'b1;
         end else begin : g_link
            assign prev = match_vec[j-1];
         end
         assign load_sel[j] = load_acc && (int'(req_entry_index) == j);
         wbps_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .load_sel   (load_sel[j]),
            .prev_match (prev),
            .match_ff   (match_vec[j]),
            .next_match (next_vec[j])
         );
      end
   endgenerate

   assign tap       = next_vec[len_sel];
   assign hit_valid = shift && (tap || req_is_last);

   assign hit.found  = tap;
   assign hit.start  = byte_position_ff - POS_W'(len_sel);
   assign hit.base   = base_address_ff;
   assign hit.offset = match_offset_ff;

   always_comb begin
      byte_position_in = byte_position_ff;
      search_done_in   = search_done_ff;
      if (scan_acc) begin
         if (req_is_last) begin
            byte_position_in = '0;
            search_done_in   = 1'b0;
         end else begin
            if (byte_position_ff != '1) begin
               byte_position_in = byte_position_ff + POS_W'(1);
            end
            if (shift && tap) begin
               search_done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
         search_done_ff   <= 1'b0;
      end else begin
         byte_position_ff <= byte_position_in;
         search_done_ff   <= search_done_in;
      end
   end

   wbps_result_pipe u_result (
      .clock             (clock),
      .reset             (reset),
      .hit_valid         (hit_valid),
      .hit               (hit),
      .busy              (busy),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_match_address (rsp_match_address)
   );

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (scan_acc && req_is_last) |=>
         (byte_position_ff == '0 && !search_done_ff && match_vec == '0))
      else $error("final byte did not restart the image");

   a_match_closes: assert property (@(posedge clock) disable iff (reset)
      (hit_valid && tap && !req_is_last) |=> search_done_ff)
      else $error("match did not end the search");

   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      search_done_ff |-> !hit_valid)
      else $error("second result for one image");

endmodule
`default_nettype wire

/* sv/wbps_cell.sv */
// One pattern position: stored byte, wildcard mark and partial match bit.
`default_nettype none
module wbps_cell
   import wbps_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_ctl_type ctl,
   input  wire logic         load_sel,
   input  wire logic         prev_match,
   output logic              match_ff,
   output logic              next_match
);

   logic [7:0] pattern_ff;
   logic       wild_ff;
   logic       match_in;
   logic       hit;

   assign hit        = wild_ff | (pattern_ff == ctl.scan_byte);
   assign next_match = hit & prev_match;

   always_comb begin
      if (ctl.clear) begin
         match_in = 1'b0;
      end else if (ctl.scan_en) begin
         match_in = next_match;
      end else begin
         match_in = match_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_sel) begin
         pattern_ff <= ctl.load_byte;
         wild_ff    <= ctl.load_wild;
      end
   end

endmodule
`default_nettype wire

/* sv/wbps_result_pipe.sv */
// Two result stages: address sum, then the output register.
`default_nettype none
module wbps_result_pipe
   import wbps_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              hit_valid,
   input  wire hit_type           hit,
   output logic                   busy,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_found,
   output logic [ADDR_W-1:0]      rsp_match_address
);

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_found_ff;
   logic [POS_W-1:0]  s1_start_ff;
   logic [ADDR_W-1:0] s1_baseoff_ff, s1_baseoff_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_found_ff;
   logic [ADDR_W-1:0] out_addr_ff, out_addr_in;
   logic              adv_out;
   logic              adv_s1;

   assign adv_out = !out_valid_ff || !rsp_stall;
   assign adv_s1  = !s1_valid_ff || adv_out;
   assign busy    = s1_valid_ff && out_valid_ff && rsp_stall;

   assign s1_baseoff_in = hit.base + {{(ADDR_W-OFFSET_W){hit.offset[OFFSET_W-1]}}, hit.offset};
   assign s1_valid_in   = adv_s1 ? hit_valid : s1_valid_ff;
   assign out_valid_in  = adv_out ? s1_valid_ff : out_valid_ff;
   assign out_addr_in   = s1_found_ff ?
                          s1_baseoff_ff + {{(ADDR_W-POS_W){1'b0}}, s1_start_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_s1 && hit_valid) begin
         s1_found_ff   <= hit.found;
         s1_start_ff   <= hit.start;
         s1_baseoff_ff <= s1_baseoff_in;
      end
      if (adv_out && s1_valid_ff) begin
         out_found_ff <= s1_found_ff;
         out_addr_ff  <= out_addr_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_found         = out_found_ff;
   assign rsp_match_address = out_addr_ff;

   // a held stage keeps its beat
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !adv_out) |=> (s1_valid_ff && $stable(s1_baseoff_ff)
                                     && $stable(s1_start_ff)))
      else $error("stage 1 lost or changed while output stalled");

   // nothing arrives while both stages are full and stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      busy |-> !hit_valid)
      else $error("result entered a full pipe");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_match_address == '0))
      else $error("not-found result carries an address");

endmodule
`default_nettype wire
